// ===== src/drt_pkg.sv =====
package drt_pkg;

  // Time bases
  localparam int unsigned MS_PER_S       = 1000;
  localparam int unsigned DEF_INTERVAL_S = 1800;
  localparam int unsigned DEF_AWAY_S     = 300;
  localparam int unsigned MIN_AWAY_S     = 30;
  localparam int unsigned RETRY_MS       = 60000;
  localparam int unsigned DEF_INTERVAL_MS = DEF_INTERVAL_S * MS_PER_S;
  localparam int unsigned DEF_AWAY_MS     = DEF_AWAY_S * MS_PER_S;

  // 65535 s in ms fits in 26 bits
  localparam int unsigned MS_W    = 26;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_WATER_EN = 3'd1,
    CFG_STAND_EN = 3'd2,
    CFG_INTERVAL = 3'd3,
    CFG_AWAY     = 3'd4
  } drt_cfg_e;

  typedef struct packed {
    logic [47:0] now_ms;
    logic [31:0] idle_ms;
    logic        pet_busy;
    logic        pet_visible;
    logic        water_accept;
    logic        stand_accept;
    logic        host_present;
  } drt_in_t;

  typedef struct packed {
    logic        water_request;
    logic        stand_request;
    logic [31:0] water_left_ms;
    logic [31:0] stand_left_ms;
    logic [31:0] accepted_count;
  } drt_out_t;

  // Per-tick control from the sequencing logic to one timer
  typedef struct packed {
    logic step;     // advance this timer for the current tick
    logic restart;  // full timer reset
    logic fwd;      // time moved forward (else backward)
    logic can_ask;  // pet is visible and not busy
    logic accept;   // host takes this timer's request
  } drt_tmr_ctrl_t;

  typedef struct packed {
    logic asked;
    logic accepted;
  } drt_tmr_stat_t;

endpackage

// ===== src/drt_stream_if.sv =====
interface drt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/drt_timer.sv =====
module drt_timer import drt_pkg::*; #(
  parameter int unsigned TIME_BITS  = 48,
  parameter logic [31:0] RstElapsed = '0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  drt_tmr_ctrl_t        ctrl_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] dt_i,
  input  logic [MS_W-1:0]      interval_ms_i,
  input  logic [31:0]          restart_el_i,
  output drt_tmr_stat_t        stat_o,
  output logic [31:0]          left_ms_o
);

  logic [31:0]          el_q, el_d;
  logic                 pend_q, pend_d;
  logic [TIME_BITS-1:0] until_q, until_d;

  logic                 dt_hi;
  logic [32:0]          fwd_sum;
  logic [31:0]          e_adv;
  logic [TIME_BITS:0]   dl_sum;
  logic [TIME_BITS-1:0] deadline;
  logic [31:0]          iv;
  logic                 asked, ok;

  assign iv    = 32'(interval_ms_i);
  assign dt_hi = (dt_i >> 32) != '0;
  assign fwd_sum = {1'b0, el_q} + {1'b0, dt_i[31:0]};

  // Elapsed time after this tick, saturating up, floored at zero down
  always_comb begin
    if (ctrl_i.fwd) begin
      e_adv = (dt_hi || fwd_sum[32]) ? '1 : fwd_sum[31:0];
    end else begin
      e_adv = (dt_hi || (dt_i[31:0] >= el_q)) ? '0 : el_q - dt_i[31:0];
    end
  end

  // Retry deadline, saturating at the top of the time range
  assign dl_sum   = {1'b0, now_i} + (TIME_BITS+1)'(RETRY_MS);
  assign deadline = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

  always_comb begin
    el_d    = el_q;
    pend_d  = pend_q;
    until_d = until_q;
    asked   = 1'b0;
    ok      = 1'b0;
    if (ctrl_i.restart) begin
      el_d    = restart_el_i;
      pend_d  = 1'b0;
      until_d = '0;
    end else if (ctrl_i.step) begin
      el_d = e_adv;
      if (pend_q) begin
        if (now_i <= until_q) begin
          asked = ctrl_i.can_ask;
          ok    = asked && ctrl_i.accept;
        end else begin
          // retry window closed: drop
          el_d    = '0;
          pend_d  = 1'b0;
          until_d = '0;
        end
      end else if (e_adv >= iv) begin
        pend_d  = 1'b1;
        until_d = deadline;
        asked   = ctrl_i.can_ask;
        ok      = asked && ctrl_i.accept;
      end
      if (ok) begin
        el_d    = '0;
        pend_d  = 1'b0;
        until_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q    <= RstElapsed;
      pend_q  <= 1'b0;
      until_q <= '0;
    end else begin
      el_q    <= el_d;
      pend_q  <= pend_d;
      until_q <= until_d;
    end
  end

  assign stat_o.asked    = asked;
  assign stat_o.accepted = ok;
  assign left_ms_o       = (el_d >= iv) ? '0 : iv - el_d;

endmodule

// ===== src/dual_interval_reminder_timer.sv =====
// Dual interval reminder timer. Each input transfer is one tick carrying host
// time and user idle time in ms plus host status flags; each tick yields
// exactly one result transfer with the water/stand request strobes, the time
// left on both timers and the running count of accepted reminders. The block
// takes one tick per clock: a tick is held in the input register while the
// timer state and the result are computed, and the result is held in an
// output register, so ticks stream at full rate and only output back-pressure
// stalls the input. Configuration writes (enable, water_enable, stand_enable,
// interval_seconds, away_seconds at indexes 0..4) are to be made by the user
// only while no tick is in flight; the block does not enforce this. Every valid
// write resets both timers; writes to other indexes are ignored.
// An interval of zero means 1800 s, an away time below 30 s means 30 s.
module dual_interval_reminder_timer import drt_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  drt_stream_if.sink           in_if,
  drt_stream_if.source         out_if
);

  // Configuration, stored as milliseconds
  logic            enable_q, water_en_q, stand_en_q;
  logic [MS_W-1:0] interval_ms_q, interval_ms_d;
  logic [MS_W-1:0] away_ms_q;
  logic [CFG_W-1:0] iv_sel, away_sel;
  logic            cfg_hit;

  // Tick state
  logic [TIME_BITS-1:0] last_time_q;
  logic                 have_last_q;
  logic                 away_q;
  logic [31:0]          count_q, count_d;

  // Input stage and output register
  drt_in_t  s1_q;
  logic     s1_valid_q;
  drt_out_t out_q, out_d;
  logic     out_valid_q;
  logic     adv;

  logic [TIME_BITS-1:0] now_t, dt;
  logic                 fwd, run, away_now, timers_live;
  drt_tmr_ctrl_t        w_ctrl, s_ctrl;
  drt_tmr_stat_t        w_stat, s_stat;
  logic [31:0]          w_left, s_left, restart_el;

  // ---- configuration decode ----
  assign iv_sel   = (cfg_data_i == '0) ? CFG_W'(DEF_INTERVAL_S) : cfg_data_i;
  assign away_sel = (cfg_data_i < CFG_W'(MIN_AWAY_S)) ? CFG_W'(MIN_AWAY_S) : cfg_data_i;

  always_comb begin
    cfg_hit       = 1'b0;
    interval_ms_d = interval_ms_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE, CFG_WATER_EN, CFG_STAND_EN, CFG_AWAY: cfg_hit = 1'b1;
        CFG_INTERVAL: begin
          cfg_hit       = 1'b1;
          interval_ms_d = MS_W'(iv_sel) * MS_W'(MS_PER_S);
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Stand timer restarts half an interval ahead (new interval on a write)
  assign restart_el = 32'(interval_ms_d >> 1);

  // ---- handshake ----
  // s1 moves to the output register whenever that register is free or drains
  assign adv         = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || adv;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // ---- tick sequencing ----
  assign now_t = TIME_BITS'(64'(s1_q.now_ms));
  assign run   = s1_q.host_present && enable_q && (water_en_q || stand_en_q);
  assign away_now = s1_q.idle_ms >= 32'(away_ms_q);

  always_comb begin
    fwd = 1'b1;
    dt  = '0;
    if (have_last_q) begin
      if (now_t >= last_time_q) begin
        dt = now_t - last_time_q;
      end else begin
        fwd = 1'b0;
        dt  = last_time_q - now_t;
      end
    end
  end

  // Timers only advance while the user is present and was present before
  assign timers_live = adv && run && !away_now && !away_q;

  always_comb begin
    w_ctrl.step    = timers_live && water_en_q;
    s_ctrl.step    = timers_live && stand_en_q;
    // Config write or first tick back from away
    w_ctrl.restart = cfg_hit || (adv && run && !away_now && away_q);
    s_ctrl.restart = w_ctrl.restart;
    w_ctrl.fwd     = fwd;
    s_ctrl.fwd     = fwd;
    w_ctrl.can_ask = !s1_q.pet_busy && s1_q.pet_visible;
    s_ctrl.can_ask = w_ctrl.can_ask;
    w_ctrl.accept  = s1_q.water_accept;
    s_ctrl.accept  = s1_q.stand_accept;
  end

  drt_timer #(
    .TIME_BITS  (TIME_BITS),
    .RstElapsed ('0)
  ) u_water (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (w_ctrl),
    .now_i         (now_t),
    .dt_i          (dt),
    .interval_ms_i (interval_ms_q),
    .restart_el_i  ('0),
    .stat_o        (w_stat),
    .left_ms_o     (w_left)
  );

  drt_timer #(
    .TIME_BITS  (TIME_BITS),
    .RstElapsed (32'(DEF_INTERVAL_MS / 2))
  ) u_stand (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (s_ctrl),
    .now_i         (now_t),
    .dt_i          (dt),
    .interval_ms_i (interval_ms_q),
    .restart_el_i  (restart_el),
    .stat_o        (s_stat),
    .left_ms_o     (s_left)
  );

  // Accept count wraps
  assign count_d = count_q + 32'(w_stat.accepted) + 32'(s_stat.accepted);

  always_comb begin
    out_d.water_request  = w_stat.asked;
    out_d.stand_request  = s_stat.asked;
    out_d.water_left_ms  = w_left;
    out_d.stand_left_ms  = s_left;
    out_d.accepted_count = count_d;
  end

  // ---- registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b1;
      water_en_q    <= 1'b1;
      stand_en_q    <= 1'b1;
      interval_ms_q <= MS_W'(DEF_INTERVAL_MS);
      away_ms_q     <= MS_W'(DEF_AWAY_MS);
      last_time_q   <= '0;
      have_last_q   <= 1'b0;
      away_q        <= 1'b0;
      count_q       <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      interval_ms_q <= interval_ms_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE:   enable_q   <= cfg_data_i[0];
          CFG_WATER_EN: water_en_q <= cfg_data_i[0];
          CFG_STAND_EN: stand_en_q <= cfg_data_i[0];
          CFG_AWAY:     away_ms_q  <= MS_W'(away_sel) * MS_W'(MS_PER_S);
          default: ;
        endcase
      end
      if (adv && run) begin
        last_time_q <= now_t;
        have_last_q <= 1'b1;
        away_q      <= away_now;
      end
      if (adv) begin
        count_q <= count_d;
      end
      if (in_if.ready) begin
        s1_valid_q <= in_if.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_q <= in_if.data;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

import drt_pkg::*;

// Shadow copy of the reminder timer: tracks config and timer state per
// accepted tick, queues the result each tick must produce, checks results.
class timer_shadow;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // config registers
  bit        cfg_on;
  bit        cfg_water_on;
  bit        cfg_stand_on;
  bit [15:0] cfg_interval_s;
  bit [15:0] cfg_away_s;

  // tick state
  bit [47:0] last_ms;
  bit        have_last;
  bit        user_away;
  bit [31:0] elapsed[2];   // 0 water, 1 stand
  bit        waiting[2];
  bit [47:0] deadline[2];
  bit [31:0] reminders;

  drt_out_t    due_results[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned water_asks;
  int unsigned stand_asks;
  int unsigned drops;

  function new();
    cfg_on         = 1'b1;
    cfg_water_on   = 1'b1;
    cfg_stand_on   = 1'b1;
    cfg_interval_s = DEF_INTERVAL_S;
    cfg_away_s     = DEF_AWAY_S;
    last_ms        = '0;
    have_last      = 1'b0;
    user_away      = 1'b0;
    reminders      = '0;
    restart_timers();
  endfunction

  function bit [31:0] interval_ms();
    bit [31:0] secs;
    secs = (cfg_interval_s == 0) ? DEF_INTERVAL_S : 32'(cfg_interval_s);
    return secs * MS_PER_S;
  endfunction

  function bit [31:0] away_limit_ms();
    bit [31:0] secs;
    secs = (cfg_away_s < MIN_AWAY_S) ? MIN_AWAY_S : 32'(cfg_away_s);
    return secs * MS_PER_S;
  endfunction

  function void restart_timers();
    elapsed[0]  = '0;
    waiting[0]  = 1'b0;
    deadline[0] = '0;
    elapsed[1]  = interval_ms() / 2;
    waiting[1]  = 1'b0;
    deadline[1] = '0;
  endfunction

  function void clear_timer(int k);
    elapsed[k]  = '0;
    waiting[k]  = 1'b0;
    deadline[k] = '0;
  endfunction

  function void write_reg(drt_cfg_e idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_ENABLE:   cfg_on         = val[0];
      CFG_WATER_EN: cfg_water_on   = val[0];
      CFG_STAND_EN: cfg_stand_on   = val[0];
      CFG_INTERVAL: cfg_interval_s = val;
      CFG_AWAY:     cfg_away_s     = val;
      default:      return;
    endcase
    restart_timers();
  endfunction

  // one timer for one tick; returns whether the host was asked
  function bit step_timer(int k, bit [47:0] now, bit fwd, bit [47:0] dt,
                          bit can_ask, bit take);
    bit [48:0] e;
    bit        asked;
    asked = 1'b0;
    if (fwd) begin
      e = 49'(elapsed[k]) + 49'(dt);
      if (e > 49'h0_FFFF_FFFF) e = 49'h0_FFFF_FFFF;
    end else begin
      e = (49'(dt) >= 49'(elapsed[k])) ? 49'd0 : 49'(elapsed[k]) - 49'(dt);
    end
    elapsed[k] = e[31:0];
    if (waiting[k]) begin
      if (now <= deadline[k]) begin
        asked = can_ask;
        if (asked && take) begin
          reminders++;
          clear_timer(k);
        end
      end else begin
        drops++;
        clear_timer(k);
      end
      return asked;
    end
    if (elapsed[k] >= interval_ms()) begin
      waiting[k]  = 1'b1;
      deadline[k] = (TIME_MAX - now < 48'(RETRY_MS)) ? TIME_MAX : now + 48'(RETRY_MS);
      asked = can_ask;
      if (asked && take) begin
        reminders++;
        clear_timer(k);
      end
    end
    return asked;
  endfunction

  function void take_tick(drt_in_t t);
    drt_out_t  r;
    bit        fwd;
    bit [47:0] dt;
    bit        can_ask;
    bit [31:0] iv;
    r = '0;
    if (t.host_present && cfg_on && (cfg_water_on || cfg_stand_on)) begin
      fwd = 1'b1;
      dt  = '0;
      if (have_last) begin
        if (t.now_ms >= last_ms) begin
          dt = t.now_ms - last_ms;
        end else begin
          fwd = 1'b0;
          dt  = last_ms - t.now_ms;
        end
      end
      last_ms   = t.now_ms;
      have_last = 1'b1;
      if (t.idle_ms >= away_limit_ms()) begin
        user_away = 1'b1;
      end else if (user_away) begin
        user_away = 1'b0;
        restart_timers();
      end else begin
        can_ask = !t.pet_busy && t.pet_visible;
        if (cfg_water_on)
          r.water_request = step_timer(0, t.now_ms, fwd, dt, can_ask, t.water_accept);
        if (cfg_stand_on)
          r.stand_request = step_timer(1, t.now_ms, fwd, dt, can_ask, t.stand_accept);
      end
    end
    iv = interval_ms();
    r.water_left_ms  = (elapsed[0] >= iv) ? 32'd0 : iv - elapsed[0];
    r.stand_left_ms  = (elapsed[1] >= iv) ? 32'd0 : iv - elapsed[1];
    r.accepted_count = reminders;
    water_asks += r.water_request;
    stand_asks += r.stand_request;
    due_results.push_back(r);
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d got %0d", results_seen, name, want, got);
    end
  endfunction

  function void match_result(drt_out_t got);
    drt_out_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: none expected, got %h", results_seen, got);
      return;
    end
    want = due_results.pop_front();
    check_field("water_request",  32'(want.water_request), 32'(got.water_request));
    check_field("stand_request",  32'(want.stand_request), 32'(got.stand_request));
    check_field("water_left_ms",  want.water_left_ms,      got.water_left_ms);
    check_field("stand_left_ms",  want.stand_left_ms,      got.stand_left_ms);
    check_field("accepted_count", want.accepted_count,     got.accepted_count);
  endfunction
endclass

module testbench;
  import drt_pkg::*;

  // Settle time before config writes and at the end of the run, long enough
  // for a tick to pass the input and output registers of the block.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  drt_stream_if #(.payload_t(drt_in_t))  in_if ();
  drt_stream_if #(.payload_t(drt_out_t)) out_if ();

  dual_interval_reminder_timer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  timer_shadow shadow = new();

  bit          tx_idle;        // sender inserts random gaps
  bit          rx_idle;        // receiver inserts random stalls
  bit [47:0]   sim_now;        // host clock for random ticks
  int unsigned ticks_sent;
  int unsigned settings_run;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stall before each transfer (or none in stretches
  // where rx_idle is off); every transfer goes to the checker.
  initial begin : result_sink
    int unsigned hold;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = rx_idle ? $urandom_range(0, 7) : 0;
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      shadow.match_result(out_if.data);
    end
  end

  // One tick transfer. valid stays high on return so back-to-back ticks
  // need no extra assignment; callers lower it before going quiet.
  task automatic drive_tick(drt_in_t t);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    shadow.take_tick(t);
    ticks_sent++;
  endtask

  // Stop sending and wait until every queued result has been checked.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all five registers back to back; only called with the block idle.
  task automatic program_timers(bit on, bit w_on, bit s_on,
                                bit [15:0] ivl, bit [15:0] away);
    drt_cfg_e    idx[5];
    bit [15:0]   val[5];
    idx = '{CFG_ENABLE, CFG_WATER_EN, CFG_STAND_EN, CFG_INTERVAL, CFG_AWAY};
    val = '{16'(on), 16'(w_on), 16'(s_on), ivl, away};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      shadow.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic drt_in_t mk_tick(logic [47:0] now, logic [31:0] idle, bit busy,
                                      bit vis, bit w_acc, bit s_acc, bit host);
    drt_in_t t;
    t.now_ms       = now;
    t.idle_ms      = idle;
    t.pet_busy     = busy;
    t.pet_visible  = vis;
    t.water_accept = w_acc;
    t.stand_accept = s_acc;
    t.host_present = host;
    return t;
  endfunction

  // Mostly plain forward ticks of up to a third of the interval, so the
  // timers come due every few ticks; the rest are backward steps, jumps past
  // the retry window, jumps anywhere in the 48-bit range, and ticks just
  // below the top of the range where the retry deadline saturates.
  function automatic drt_in_t random_tick();
    drt_in_t     t;
    int unsigned pick;
    bit [31:0]   iv;
    bit [31:0]   away_lim;
    bit [47:0]   back;
    iv       = shadow.interval_ms();
    away_lim = shadow.away_limit_ms();
    pick     = $urandom_range(0, 99);
    if (pick < 84) begin
      sim_now = sim_now + $urandom_range(0, iv / 3 + 1);
    end else if (pick < 91) begin
      back    = $urandom_range(0, iv / 4 + 1);
      sim_now = (back > sim_now) ? 48'd0 : sim_now - back;
    end else if (pick < 96) begin
      sim_now = sim_now + RETRY_MS + $urandom_range(1, 3 * RETRY_MS);
    end else if (pick < 98) begin
      sim_now = {16'($urandom), 32'($urandom)};
    end else begin
      sim_now = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 70000);
    end
    t.now_ms = sim_now;

    // user mostly active; short away spells, some right at the threshold
    pick = $urandom_range(0, 99);
    if (pick < 93)      t.idle_ms = $urandom_range(0, away_lim - 1);
    else if (pick < 95) t.idle_ms = away_lim + $urandom_range(0, 1);
    else if (pick < 97) t.idle_ms = $urandom_range(away_lim, away_lim + 100000);
    else                t.idle_ms = $urandom;

    t.pet_busy     = ($urandom_range(0, 3) == 0);
    t.pet_visible  = ($urandom_range(0, 4) != 0);
    t.water_accept = $urandom_range(0, 1);
    t.stand_accept = $urandom_range(0, 1);
    t.host_present = ($urandom_range(0, 19) != 0);
    return t;
  endfunction

  task automatic run_phase(bit on, bit w_on, bit s_on, bit [15:0] ivl,
                           bit [15:0] away, int unsigned n, bit tx_gaps, bit rx_gaps);
    drain();
    program_timers(on, w_on, s_on, ivl, away);
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    repeat (n) drive_tick(random_tick());
    settings_run++;
  endtask

  initial begin : stimulus
    drt_in_t directed[$];

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_ENABLE;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at reset config: 1800 s interval, stand timer
    // already at 900 s, away threshold 300 s.
    directed.push_back(mk_tick(48'd1000, 0, 0, 1, 0, 0, 0));       // host absent
    directed.push_back(mk_tick(48'd1000, 0, 0, 1, 0, 0, 1));       // first tick, no time
    directed.push_back(mk_tick(48'd901000, 0, 0, 1, 0, 0, 1));     // stand due, refused
    directed.push_back(mk_tick(48'd902000, 0, 1, 1, 0, 1, 1));     // busy: no request
    directed.push_back(mk_tick(48'd903000, 0, 0, 1, 0, 1, 1));     // stand retry taken
    directed.push_back(mk_tick(48'd1801000, 0, 0, 1, 1, 0, 1));    // water due and taken
    directed.push_back(mk_tick(48'd1000, 0, 0, 1, 0, 0, 1));       // time runs backward
    directed.push_back(mk_tick(48'd2000, 300000, 0, 1, 0, 0, 1));  // idle at threshold
    directed.push_back(mk_tick(48'd500000, 32'hFFFF_FFFF, 0, 1, 0, 0, 1)); // still away
    directed.push_back(mk_tick(48'd501000, 299999, 0, 1, 0, 0, 1)); // back: timers restart
    // huge forward step: elapsed saturates, deadline clamps at top of range
    directed.push_back(mk_tick(48'hFFFF_FFFF_F000, 0, 0, 0, 0, 0, 1));
    directed.push_back(mk_tick(48'hFFFF_FFFF_FFFF, 0, 0, 1, 1, 1, 1)); // both taken
    directed.push_back(mk_tick(48'd0, 0, 0, 1, 1, 1, 1));          // accept, no request
    directed.push_back(mk_tick(48'd1800000, 0, 1, 1, 0, 0, 1));    // both due, busy
    directed.push_back(mk_tick(48'd1860000, 0, 0, 1, 0, 0, 1));    // last ms of retry
    directed.push_back(mk_tick(48'd1860001, 0, 0, 1, 0, 0, 1));    // retry expired: drop
    directed.push_back(mk_tick(48'd1860001, 0, 1, 0, 1, 1, 1));    // busy, hidden, no dt
    directed.push_back(mk_tick(48'd2000000, 0, 0, 0, 0, 0, 0));    // absent with time jump
    foreach (directed[i]) drive_tick(directed[i]);
    settings_run++;
    sim_now = 48'd2000000;

    // Random phases; each starts from an idle block with fresh registers.
    // Extremes: interval 0 (default) / 1 / 65535, away 0 / 29 / 30 / 65535,
    // every enable combination that matters.
    run_phase(1, 1, 1, 16'd1,     16'd0,     200, 1, 1);
    run_phase(1, 1, 1, 16'd2,     16'd29,    180, 0, 1);
    run_phase(1, 1, 1, 16'd0,     16'd30,    150, 1, 0);
    run_phase(1, 1, 1, 16'd65535, 16'd65535, 120, 0, 0);
    run_phase(1, 1, 0, 16'd1,     16'd31,    150, 1, 1);
    run_phase(1, 0, 1, 16'd3,     16'd45,    150, 1, 1);
    run_phase(1, 0, 0, 16'd1,     16'd30,     60, 1, 1);
    run_phase(0, 1, 1, 16'd1,     16'd30,     60, 1, 1);
    run_phase(1, 1, 1, 16'($urandom_range(1, 4)), 16'($urandom_range(0, 100)),
              200, 1, 1);
    run_phase(1, 1, 1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              100, 1, 1);
    drain();

    $display("covered %0d ticks over %0d register settings, %0d results checked",
             ticks_sent, settings_run, shadow.results_seen);
    $display("requests: %0d water, %0d stand; %0d reminders taken, %0d dropped",
             shadow.water_asks, shadow.stand_asks, shadow.reminders, shadow.drops);
    if (shadow.mismatches == 0 && shadow.due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
